/* rtl/core/nsa_pkg.sv */
// Shared types, codes and helpers for the NMEA sentence assembler.
// Depends on nothing; every other file of the block but the checker refers to it by scoped name.
package nsa_pkg;

  // Request codes on the input channel
  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Event codes returned for received characters
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_COMMIT  = 2'd1;
  localparam logic [1:0] EV_RESTART = 2'd2;
  localparam logic [1:0] EV_DROP    = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Checksum tracking progress
  localparam logic [2:0] CK_OPEN = 3'd0;
  localparam logic [2:0] CK_STAR = 3'd1;
  localparam logic [2:0] CK_HI   = 3'd2;
  localparam logic [2:0] CK_DONE = 3'd3;
  localparam logic [2:0] CK_BAD  = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic        is_rx;
    logic        is_pop;
    logic        is_read;
    logic [7:0]  ch;
    logic [31:0] time_ms;
    logic [6:0]  idx;
  } item_t;

  // Uppercase hex character of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    return (v < 4'd10) ? (8'h30 + w) : (8'h37 + w);
  endfunction

endpackage

/* rtl/core/nmea_sentence_assembler_top.sv */
// Top level of the NMEA sentence assembler: front decode, request queue, back end.
// Depends on nsa_pkg, nsa_front, nsa_queue and nsa_back.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request word: receive a
//   character (opcode 0), pop the oldest stored sentence (1), read a character
//   of the popped sentence (2); code 3 is a no-op. Every request returns
//   exactly one result word on the output channel (out_valid_o/out_ready_i).
//   Received characters are framed from '$' to LF into a ring of RING_SLOTS
//   slots of SENTENCE_CAPACITY characters; CR is dropped, a second '$'
//   restarts the sentence, an overlong one is dropped. The ring has no full
//   check: new sentences overwrite old ones.
// Timing:
//   An accepted word is registered in the request queue, then its result in the
//   result register. Throughput is one word per cycle unless the output stalls; each
//   request takes one pass through the back end, whose text memory has one write
//   and one registered read port. A two-entry queue sits between front and back, and
//   the result register accepts a new word in the same cycle the old one is taken.
// Reset:
//   Asynchronous, active low. Clears framing state and ring pointers; the slot
//   memories need no clearing. When the receiver stalls, the result holds, the
//   back end stops and in_ready_o drops once two words wait in the queue.
module nmea_sentence_assembler_top #(
  parameter int SENTENCE_CAPACITY = 128,
  parameter int RING_SLOTS        = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_in_i,
  input  logic [31:0] time_ms_i,
  input  logic [6:0]  char_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  event_res_o,
  output logic        sentence_found_o,
  output logic [31:0] sentence_time_o,
  output logic [7:0]  sentence_length_o,
  output logic        checksum_ok_o,
  output logic [7:0]  char_out_o
);

  logic           q_room;
  logic           q_push;
  nsa_pkg::item_t q_item_in;
  logic           q_valid;
  logic           q_pop;
  nsa_pkg::item_t q_item_out;

  // Accept and classify requests
  nsa_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .char_in_i    (char_in_i),
    .time_ms_i    (time_ms_i),
    .char_index_i (char_index_i),
    .q_room_i     (q_room),
    .q_push_o     (q_push),
    .q_item_o     (q_item_in)
  );

  // Decouple front and back so each can stall on its own
  nsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item_in),
    .room_o  (q_room),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item_out)
  );

  // Frame, check, store and answer
  nsa_back #(
    .SENTENCE_CAPACITY (SENTENCE_CAPACITY),
    .RING_SLOTS        (RING_SLOTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item_out),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .sentence_found_o  (sentence_found_o),
    .sentence_time_o   (sentence_time_o),
    .sentence_length_o (sentence_length_o),
    .checksum_ok_o     (checksum_ok_o),
    .char_out_o        (char_out_o)
  );

endmodule

/* rtl/core/nsa_front.sv */
// Front end of the NMEA sentence assembler: input handshake and request decode.
// Depends on nsa_pkg.
module nsa_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         char_in_i,
  input  logic [31:0]        time_ms_i,
  input  logic [6:0]         char_index_i,
  input  logic               q_room_i,
  output logic               q_push_o,
  output nsa_pkg::item_t     q_item_o
);

  assign in_ready_o = q_room_i;
  assign q_push_o   = in_valid_i & q_room_i;

  // Decode the request; unused codes pass as a no-op
  always_comb begin
    q_item_o         = '0;
    q_item_o.ch      = char_in_i;
    q_item_o.time_ms = time_ms_i;
    q_item_o.idx     = char_index_i;
    case (opcode_i)
      nsa_pkg::OP_RX:   q_item_o.is_rx   = 1'b1;
      nsa_pkg::OP_POP:  q_item_o.is_pop  = 1'b1;
      nsa_pkg::OP_READ: q_item_o.is_read = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/core/nsa_queue.sv */
// Two-entry request queue between front and back of the sentence assembler.
// Depends on nsa_pkg.
module nsa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nsa_pkg::item_t item_i,
  output logic           room_o,
  input  logic           pop_i,
  output logic           valid_o,
  output nsa_pkg::item_t item_o
);

  nsa_pkg::item_t entry_q [nsa_pkg::QUEUE_DEPTH];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign room_o  = (cnt_q != 2'(nsa_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/nsa_back.sv */
// Back end of the sentence assembler: framing, checksum, slot ring and result register.
// Depends on nsa_pkg; holds the sentence text and slot info memories.
module nsa_back #(
  parameter int SENTENCE_CAPACITY = 128,
  parameter int RING_SLOTS        = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  nsa_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     event_res_o,
  output logic           sentence_found_o,
  output logic [31:0]    sentence_time_o,
  output logic [7:0]     sentence_length_o,
  output logic           checksum_ok_o,
  output logic [7:0]     char_out_o
);

  localparam int CAPW      = $clog2(SENTENCE_CAPACITY);
  localparam int LEN_W     = $clog2(SENTENCE_CAPACITY + 1);
  localparam int SW        = $clog2(RING_SLOTS);
  localparam int IDX_W     = (CAPW > 7) ? CAPW : 7;
  localparam int CMP_W     = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int TXT_AW    = SW + 1 + CAPW;
  localparam int TXT_DEPTH = 1 << TXT_AW;
  localparam int INFO_W    = 32 + LEN_W + 1;

  // Capture state
  logic              capturing_q, capturing_d;
  logic [LEN_W-1:0]  cur_len_q, cur_len_d;
  logic [31:0]       cur_time_q, cur_time_d;
  logic [7:0]        xor_q, xor_d;
  logic [2:0]        ck_q, ck_d;
  // Ring state; each slot owns two text rows, bank selects the committed one
  logic [SW-1:0]         wr_slot_q, wr_slot_d;
  logic [SW-1:0]         rd_slot_q, rd_slot_d;
  logic [SW-1:0]         pop_slot_q, pop_slot_d;
  logic [RING_SLOTS-1:0] bank_q, bank_d;
  logic [LEN_W-1:0]      pop_len_q, pop_len_d;
  logic                  last_pop_q, last_pop_d;
  // Result register
  logic              out_valid_q;
  logic [1:0]        ev_q, ev_d;
  logic              found_q, found_d;
  logic              rd_ok_q, rd_ok_d;

  // Memories
  logic [7:0]        txt_mem [0:TXT_DEPTH-1];
  logic [INFO_W-1:0] info_mem [0:RING_SLOTS-1];
  logic [7:0]        txt_rd_q;
  logic [INFO_W-1:0] info_rd_q;

  logic              fire;
  logic              txt_we;
  logic [CAPW-1:0]   txt_wpos;
  logic [7:0]        txt_wd;
  logic [TXT_AW-1:0] txt_wa, txt_ra;
  logic              info_we;
  logic [INFO_W-1:0] info_wd;
  logic [SW-1:0]     wr_next, rd_next;
  logic [IDX_W-1:0]  idx_ext;
  logic [LEN_W-1:0]  pop_len_eff, info_rd_len;
  logic [7:0]        c;

  // Advance whenever the result register is free or being drained
  assign fire        = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o     = fire;
  assign c           = q_item_i.ch;
  assign idx_ext     = IDX_W'(q_item_i.idx);
  assign info_rd_len = info_rd_q[LEN_W:1];
  assign pop_len_eff = last_pop_q ? info_rd_len : pop_len_q;
  assign wr_next     = (wr_slot_q == SW'(RING_SLOTS - 1)) ? '0 : wr_slot_q + 1'b1;
  assign rd_next     = (rd_slot_q == SW'(RING_SLOTS - 1)) ? '0 : rd_slot_q + 1'b1;
  assign txt_wa      = {wr_slot_q, ~bank_q[wr_slot_q], txt_wpos};
  assign txt_ra      = {pop_slot_q, bank_q[pop_slot_q], idx_ext[CAPW-1:0]};
  assign info_wd     = {cur_time_q, cur_len_q, (ck_q == nsa_pkg::CK_DONE)};

  always_comb begin
    capturing_d = capturing_q;
    cur_len_d   = cur_len_q;
    cur_time_d  = cur_time_q;
    xor_d       = xor_q;
    ck_d        = ck_q;
    wr_slot_d   = wr_slot_q;
    rd_slot_d   = rd_slot_q;
    pop_slot_d  = pop_slot_q;
    bank_d      = bank_q;
    pop_len_d   = pop_len_eff;
    last_pop_d  = 1'b0;
    ev_d        = nsa_pkg::EV_NONE;
    found_d     = 1'b0;
    rd_ok_d     = 1'b0;
    txt_we      = 1'b0;
    txt_wpos    = cur_len_q[CAPW-1:0];
    txt_wd      = c;
    info_we     = 1'b0;

    if (q_item_i.is_rx) begin
      if (!capturing_q || c == nsa_pkg::CH_DOLLAR) begin
        if (c == nsa_pkg::CH_DOLLAR) begin
          // Start a sentence: store the dollar and latch the time
          capturing_d = 1'b1;
          cur_len_d   = LEN_W'(1);
          cur_time_d  = q_item_i.time_ms;
          xor_d       = 8'h00;
          ck_d        = nsa_pkg::CK_OPEN;
          txt_we      = 1'b1;
          txt_wpos    = '0;
          txt_wd      = nsa_pkg::CH_DOLLAR;
          ev_d        = capturing_q ? nsa_pkg::EV_RESTART : nsa_pkg::EV_NONE;
        end
      end else if (c == nsa_pkg::CH_LF) begin
        // Commit: flip the slot onto the captured row
        info_we             = 1'b1;
        bank_d[wr_slot_q]   = ~bank_q[wr_slot_q];
        wr_slot_d           = wr_next;
        capturing_d         = 1'b0;
        ev_d                = nsa_pkg::EV_COMMIT;
        if (wr_slot_q == pop_slot_q) begin
          pop_len_d = cur_len_q;
        end
      end else if (c == nsa_pkg::CH_CR) begin
        // drop carriage return
      end else if (cur_len_q >= LEN_W'(SENTENCE_CAPACITY)) begin
        capturing_d = 1'b0;
        ev_d        = nsa_pkg::EV_DROP;
      end else begin
        txt_we    = 1'b1;
        cur_len_d = cur_len_q + 1'b1;
        case (ck_q)
          nsa_pkg::CK_OPEN: begin
            if (c == nsa_pkg::CH_STAR) begin
              ck_d = nsa_pkg::CK_STAR;
            end else if (!(c inside {[nsa_pkg::CH_PRINT_LO:nsa_pkg::CH_PRINT_HI]})) begin
              ck_d = nsa_pkg::CK_BAD;
            end else begin
              xor_d = xor_q ^ c;
            end
          end
          nsa_pkg::CK_STAR: begin
            ck_d = (c == nsa_pkg::hex_digit(xor_q[7:4])) ? nsa_pkg::CK_HI : nsa_pkg::CK_BAD;
          end
          nsa_pkg::CK_HI: begin
            ck_d = (c == nsa_pkg::hex_digit(xor_q[3:0])) ? nsa_pkg::CK_DONE : nsa_pkg::CK_BAD;
          end
          default: ck_d = nsa_pkg::CK_BAD;
        endcase
      end
    end

    if (q_item_i.is_pop && rd_slot_q != wr_slot_q) begin
      found_d    = 1'b1;
      pop_slot_d = rd_slot_q;
      rd_slot_d  = rd_next;
      last_pop_d = 1'b1;
    end

    if (q_item_i.is_read) begin
      rd_ok_d = (CMP_W'(idx_ext) < CMP_W'(pop_len_eff));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      cur_len_q   <= '0;
      cur_time_q  <= '0;
      xor_q       <= '0;
      ck_q        <= nsa_pkg::CK_OPEN;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      pop_slot_q  <= '0;
      bank_q      <= '0;
      pop_len_q   <= '0;
      last_pop_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        capturing_q <= capturing_d;
        cur_len_q   <= cur_len_d;
        cur_time_q  <= cur_time_d;
        xor_q       <= xor_d;
        ck_q        <= ck_d;
        wr_slot_q   <= wr_slot_d;
        rd_slot_q   <= rd_slot_d;
        pop_slot_q  <= pop_slot_d;
        bank_q      <= bank_d;
        pop_len_q   <= pop_len_d;
        last_pop_q  <= last_pop_d;
      end
      out_valid_q <= fire | (out_valid_q & ~out_ready_i);
    end
  end

  // Result payload, memory writes and registered memory reads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_q      <= ev_d;
      found_q   <= found_d;
      rd_ok_q   <= rd_ok_d;
      txt_rd_q  <= txt_mem[txt_ra];
      info_rd_q <= info_mem[rd_slot_q];
      if (txt_we) begin
        txt_mem[txt_wa] <= txt_wd;
      end
      if (info_we) begin
        info_mem[wr_slot_q] <= info_wd;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = ev_q;
  assign sentence_found_o  = found_q;
  assign sentence_time_o   = found_q ? info_rd_q[INFO_W-1:LEN_W+1] : 32'd0;
  assign sentence_length_o = found_q ? 8'(info_rd_len) : 8'd0;
  assign checksum_ok_o     = found_q & info_rd_q[0];
  assign char_out_o        = rd_ok_q ? txt_rd_q : 8'd0;

endmodule

/* rtl/core/nsa_checker.sv */
// Port-level checks for the NMEA sentence assembler, bound to its top level.
// Depends on nmea_sentence_assembler_top.
module nsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  event_res_o,
  input logic        sentence_found_o,
  input logic [31:0] sentence_time_o,
  input logic [7:0]  sentence_length_o,
  input logic        checksum_ok_o,
  input logic [7:0]  char_out_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
      && $stable(sentence_found_o) && $stable(sentence_time_o)
      && $stable(sentence_length_o) && $stable(checksum_ok_o) && $stable(char_out_o))
    else $error("result word changed while stalled");

  // A receive event excludes pop and read answers
  a_event_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != 2'd0 |-> !sentence_found_o && char_out_o == 8'd0)
    else $error("event mixed with pop or read answer");

  // Sentence fields stay zero unless a sentence was found
  a_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sentence_found_o |->
      sentence_time_o == 32'd0 && sentence_length_o == 8'd0 && !checksum_ok_o)
    else $error("sentence fields set without a found sentence");

  // No result right out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind nmea_sentence_assembler_top nsa_checker u_nsa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .event_res_o       (event_res_o),
  .sentence_found_o  (sentence_found_o),
  .sentence_time_o   (sentence_time_o),
  .sentence_length_o (sentence_length_o),
  .checksum_ok_o     (checksum_ok_o),
  .char_out_o        (char_out_o)
);

/* sim/nmea_sentence_assembler_top_tb.sv */
// Self-checking testbench for nmea_sentence_assembler_top: directed and random words,
// an in-bench sentence predictor, and random idling on both channels.
// Depends on nsa_pkg and the RTL of nmea_sentence_assembler_top.
module nmea_sentence_assembler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP   = 128;
  localparam int SLOTS = 8;

  // Code 3 has no name in the package: the block treats it as a no-op
  localparam logic [1:0] OP_IDLE = 2'd3;

  localparam logic [7:0] ASC_ZERO    = 8'h30;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam logic [7:0] ASC_LOWER_A = 8'h61;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_WORDS   = 1000;
  localparam int DRAIN_CYCLES   = 8;

  // Sentence shapes produced by the generator
  localparam int FL_GOOD      = 0;
  localparam int FL_BAD_SUM   = 1;
  localparam int FL_LOWER_HEX = 2;
  localparam int FL_BAD_CHAR  = 3;
  localparam int FL_NO_STAR   = 4;
  localparam int FL_TRAILING  = 5;
  localparam int FL_RESTART   = 6;
  localparam int FL_SHORT_SUM = 7;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [31:0] ms;
    logic [6:0]  idx;
  } request_t;

  typedef struct {
    logic [1:0]  ev;
    logic        found;
    logic [31:0] stamp;
    logic [7:0]  len;
    logic        ok;
    logic [7:0]  ch;
  } sentence_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i     = OP_IDLE;
  logic [7:0]  char_in_i    = 8'h00;
  logic [31:0] time_ms_i    = 32'h0;
  logic [6:0]  char_index_i = 7'h00;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [1:0]  event_res_o;
  logic        sentence_found_o;
  logic [31:0] sentence_time_o;
  logic [7:0]  sentence_length_o;
  logic        checksum_ok_o;
  logic [7:0]  char_out_o;

  nmea_sentence_assembler_top #(
    .SENTENCE_CAPACITY(CAP),
    .RING_SLOTS       (SLOTS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .char_in_i        (char_in_i),
    .time_ms_i        (time_ms_i),
    .char_index_i     (char_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .sentence_found_o (sentence_found_o),
    .sentence_time_o  (sentence_time_o),
    .sentence_length_o(sentence_length_o),
    .checksum_ok_o    (checksum_ok_o),
    .char_out_o       (char_out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hold reset from the start, then release it for good
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sentence predictor: framing state, the sentence under capture and the ring
  // ---------------------------------------------------------------------------
  bit          in_sentence = 1'b0;
  int          cur_len     = 0;
  logic [31:0] cur_stamp   = 32'h0;
  logic [7:0]  xor_acc     = 8'h00;
  logic [2:0]  ck_prog     = nsa_pkg::CK_OPEN;
  logic [7:0]  cur_chars [CAP]   = '{default: 8'h00};
  logic [7:0]  ring_text [SLOTS][CAP];
  logic [31:0] ring_stamp [SLOTS] = '{default: 32'h0};
  int          ring_len   [SLOTS] = '{default: 0};
  bit          ring_ok    [SLOTS] = '{default: 1'b0};
  int          wr_ptr  = 0;
  int          rd_ptr  = 0;
  int          pop_ptr = 0;

  sentence_result_t expected_q[$];
  request_t         pending_q[$];

  int mismatches  = 0;
  int idle_cycles = 0;
  int random_words;

  // Uppercase (or, to break a checksum, lowercase) hex character of a nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return ASC_ZERO + {4'h0, n};
    return (lower ? ASC_LOWER_A : ASC_UPPER_A) + {4'h0, n} - 8'd10;
  endfunction

  task automatic open_sentence(input logic [31:0] ms);
    cur_stamp    = ms;
    cur_len      = 1;
    cur_chars[0] = nsa_pkg::CH_DOLLAR;
    xor_acc      = 8'h00;
    ck_prog      = nsa_pkg::CK_OPEN;
    in_sentence  = 1'b1;
  endtask

  // Advance the checksum tracker by one stored character
  task automatic track_checksum(input logic [7:0] c);
    case (ck_prog)
      nsa_pkg::CK_OPEN: begin
        if (c == nsa_pkg::CH_STAR) ck_prog = nsa_pkg::CK_STAR;
        else if (c < nsa_pkg::CH_PRINT_LO || c > nsa_pkg::CH_PRINT_HI) ck_prog = nsa_pkg::CK_BAD;
        else xor_acc = xor_acc ^ c;
      end
      nsa_pkg::CK_STAR: begin
        ck_prog = (c == nibble_char(xor_acc[7:4], 1'b0)) ? nsa_pkg::CK_HI : nsa_pkg::CK_BAD;
      end
      nsa_pkg::CK_HI: begin
        ck_prog = (c == nibble_char(xor_acc[3:0], 1'b0)) ? nsa_pkg::CK_DONE : nsa_pkg::CK_BAD;
      end
      default: ck_prog = nsa_pkg::CK_BAD;
    endcase
  endtask

  // Work out the result word of one accepted request and update the state
  task automatic assemble_predict(input request_t rq, output sentence_result_t res);
    int k;
    res = '{ev: nsa_pkg::EV_NONE, found: 1'b0, stamp: 32'h0, len: 8'h00, ok: 1'b0,
            ch: 8'h00};
    case (rq.op)
      nsa_pkg::OP_RX: begin
        if (!in_sentence) begin
          // Hunting: everything but a dollar is dropped
          if (rq.ch == nsa_pkg::CH_DOLLAR) open_sentence(rq.ms);
        end else if (rq.ch == nsa_pkg::CH_LF) begin
          for (k = 0; k < CAP; k++) ring_text[wr_ptr][k] = cur_chars[k];
          ring_stamp[wr_ptr] = cur_stamp;
          ring_len[wr_ptr]   = cur_len;
          ring_ok[wr_ptr]    = (ck_prog == nsa_pkg::CK_DONE);
          wr_ptr      = (wr_ptr + 1) % SLOTS;
          in_sentence = 1'b0;
          res.ev      = nsa_pkg::EV_COMMIT;
        end else if (rq.ch == nsa_pkg::CH_CR) begin
          // carriage return is simply dropped
        end else if (rq.ch == nsa_pkg::CH_DOLLAR) begin
          open_sentence(rq.ms);
          res.ev = nsa_pkg::EV_RESTART;
        end else if (cur_len >= CAP) begin
          in_sentence = 1'b0;
          res.ev      = nsa_pkg::EV_DROP;
        end else begin
          cur_chars[cur_len] = rq.ch;
          cur_len++;
          track_checksum(rq.ch);
        end
      end
      nsa_pkg::OP_POP: begin
        // No full check in the ring: equal pointers always read as empty
        if (rd_ptr != wr_ptr) begin
          pop_ptr   = rd_ptr;
          res.found = 1'b1;
          res.stamp = ring_stamp[rd_ptr];
          res.len   = 8'(ring_len[rd_ptr]);
          res.ok    = ring_ok[rd_ptr];
          rd_ptr    = (rd_ptr + 1) % SLOTS;
        end
      end
      nsa_pkg::OP_READ: begin
        if (int'(rq.idx) < ring_len[pop_ptr]) res.ch = ring_text[pop_ptr][rq.idx];
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic queue_word(input logic [1:0] op, input logic [7:0] ch, input logic [6:0] idx,
                            input bit counted);
    request_t rq;
    rq.op  = op;
    rq.ch  = ch;
    rq.ms  = $urandom;
    rq.idx = idx;
    pending_q.push_back(rq);
    if (counted) random_words++;
  endtask

  task automatic queue_char(input logic [7:0] ch);
    queue_word(nsa_pkg::OP_RX, ch, 7'($urandom), 1'b1);
  endtask

  // Printable body character that neither ends the body nor restarts the sentence
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == nsa_pkg::CH_STAR || c == nsa_pkg::CH_DOLLAR);
    return c;
  endfunction

  function automatic logic [6:0] read_index();
    return ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 24)) : 7'($urandom);
  endfunction

  // Queue one framed sentence; the shape decides how it is broken, if at all
  task automatic queue_sentence(input int body_len, input int shape);
    logic [7:0] acc;
    logic [7:0] c;
    logic [3:0] lo_nib;
    int k;
    acc = 8'h00;
    queue_char(nsa_pkg::CH_DOLLAR);
    for (k = 0; k < body_len; k++) begin
      c = body_char();
      if (shape == FL_BAD_CHAR && k == body_len / 2) begin
        c = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
        if (c == nsa_pkg::CH_LF || c == nsa_pkg::CH_CR) c = 8'h01;
      end
      queue_char(c);
      acc = acc ^ c;
      // A stray CR inside the body must not count
      if ($urandom_range(0, 30) == 0) queue_char(nsa_pkg::CH_CR);
      if (shape == FL_RESTART && k == body_len / 2) begin
        queue_char(nsa_pkg::CH_DOLLAR);
        acc = 8'h00;
      end
    end
    if (shape != FL_NO_STAR) begin
      queue_char(nsa_pkg::CH_STAR);
      queue_char(nibble_char(acc[7:4], shape == FL_LOWER_HEX));
      lo_nib = (shape == FL_BAD_SUM) ? acc[3:0] + 4'd1 : acc[3:0];
      if (shape != FL_SHORT_SUM) queue_char(nibble_char(lo_nib, shape == FL_LOWER_HEX));
      if (shape == FL_TRAILING) queue_char(body_char());
    end
    if ($urandom_range(0, 3) != 0) queue_char(nsa_pkg::CH_CR);
    queue_char(nsa_pkg::CH_LF);
  endtask

  task automatic queue_pops_and_reads();
    repeat ($urandom_range(0, 2)) begin
      queue_word(nsa_pkg::OP_POP, 8'($urandom), 7'($urandom), 1'b1);
      repeat ($urandom_range(0, 3)) begin
        queue_word(nsa_pkg::OP_READ, 8'($urandom), read_index(), 1'b1);
      end
    end
  endtask

  // Idle length for either side: mostly none, a few long ones, none in a calm phase
  function automatic int idle_length(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued words, predict each one as it is accepted
  // ---------------------------------------------------------------------------
  int send_gap        = 0;
  int send_phase_left = 0;
  bit send_calm       = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    request_t         rq;
    sentence_result_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rq = '{op: opcode_i, ch: char_in_i, ms: time_ms_i, idx: char_index_i};
        assemble_predict(rq, res);
        expected_q.push_back(res);
      end
      // The channel is free for a new word once the current one is taken
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          rq = pending_q.pop_front();
          opcode_i     <= rq.op;
          char_in_i    <= rq.ch;
          time_ms_i    <= rq.ms;
          char_index_i <= rq.idx;
          in_valid_i   <= 1'b1;
          if (send_phase_left == 0) begin
            send_calm       = ($urandom_range(0, 3) == 0);
            send_phase_left = $urandom_range(20, 120);
          end else begin
            send_phase_left--;
          end
          send_gap = idle_length(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result word with the oldest prediction, stall at random
  // ---------------------------------------------------------------------------
  int recv_stall      = 0;
  int recv_phase_left = 0;
  bit recv_calm       = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    sentence_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result word with nothing expected: %s%0d %0b %h %0d %0b %h",
                     $realtime, "ev/found/time/len/ok/ch=", event_res_o, sentence_found_o,
                     sentence_time_o, sentence_length_o, checksum_ok_o, char_out_o);
        end else begin
          want = expected_q.pop_front();
          if (event_res_o !== want.ev || sentence_found_o !== want.found ||
              sentence_time_o !== want.stamp || sentence_length_o !== want.len ||
              checksum_ok_o !== want.ok || char_out_o !== want.ch) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch exp ev=%0d found=%0b time=%h len=%0d ok=%0b ch=%h",
                       $realtime, want.ev, want.found, want.stamp, want.len, want.ok, want.ch);
              $display("%0t:          got ev=%0d found=%0b time=%h len=%0d ok=%0b ch=%h",
                       $realtime, event_res_o, sentence_found_o, sentence_time_o,
                       sentence_length_o, checksum_ok_o, char_out_o);
            end
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        // Start stalls right after a taken word and also at random times
        if ((out_valid_o && out_ready_i) || $urandom_range(0, 15) == 0) begin
          if (recv_phase_left == 0) begin
            recv_calm       = ($urandom_range(0, 3) == 0);
            recv_phase_left = $urandom_range(20, 120);
          end else begin
            recv_phase_left--;
          end
          recv_stall = idle_length(recv_calm);
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves a word for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("nmea_sentence_assembler_top verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    int sel;
    int body;
    random_words = 0;

    // Directed part. Hunting ignores anything but a dollar.
    queue_char(8'h78);
    // A complete valid sentence "$A*41" with CR LF; its pop makes reads legal
    queue_word(nsa_pkg::OP_RX, nsa_pkg::CH_DOLLAR, 7'h00, 1'b1);
    pending_q[$].ms = 32'h0;
    queue_char(ASC_UPPER_A);
    queue_char(nsa_pkg::CH_STAR);
    queue_char(nibble_char(4'h4, 1'b0));
    queue_char(nibble_char(4'h1, 1'b0));
    queue_char(nsa_pkg::CH_CR);
    queue_char(nsa_pkg::CH_LF);
    queue_word(nsa_pkg::OP_POP, 8'h00, 7'h00, 1'b1);
    queue_word(nsa_pkg::OP_READ, 8'hFF, 7'd0, 1'b1);
    queue_word(nsa_pkg::OP_READ, 8'h00, 7'd4, 1'b1);
    // Index beyond the stored length reads zero
    queue_word(nsa_pkg::OP_READ, 8'h00, 7'h7F, 1'b1);
    // Empty pop, then the unused code with every field at its top
    queue_word(nsa_pkg::OP_POP, 8'h00, 7'h00, 1'b1);
    queue_word(OP_IDLE, 8'hFF, 7'h7F, 1'b1);
    pending_q[$].ms = 32'hFFFF_FFFF;
    // Non-printable characters at both ends of the byte range, a restart by dollar,
    // and a sentence ending right after the star
    queue_word(nsa_pkg::OP_RX, nsa_pkg::CH_DOLLAR, 7'h00, 1'b1);
    pending_q[$].ms = 32'hFFFF_FFFF;
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_word(nsa_pkg::OP_RX, nsa_pkg::CH_DOLLAR, 7'h00, 1'b1);
    pending_q[$].ms = 32'h0;
    queue_char(nsa_pkg::CH_STAR);
    queue_char(nsa_pkg::CH_LF);
    queue_word(nsa_pkg::OP_POP, 8'h00, 7'h00, 1'b1);
    queue_word(nsa_pkg::OP_READ, 8'h00, 7'd1, 1'b1);

    // Random part: full-capacity and overlong sentences first, then a mix
    random_words = 0;
    queue_sentence(CAP - 4, FL_GOOD);
    queue_sentence(CAP + 2, FL_GOOD);
    queue_pops_and_reads();
    while (random_words < RANDOM_WORDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        body = ($urandom_range(0, 14) == 0) ? $urandom_range(21, CAP + 2) : $urandom_range(0, 20);
        queue_sentence(body, $urandom_range(0, 1) ? FL_GOOD : $urandom_range(FL_BAD_SUM,
                                                                              FL_SHORT_SUM));
      end else if (sel < 80) begin
        // Line noise; mostly dropped while hunting
        repeat ($urandom_range(1, 6)) begin
          queue_word(nsa_pkg::OP_RX, 8'($urandom), 7'($urandom), 1'b0);
        end
      end else if (sel < 85) begin
        // Run the write pointer around the ring without popping
        repeat (SLOTS + 1) queue_sentence($urandom_range(0, 6), FL_GOOD);
      end else if (sel < 90) begin
        queue_word(OP_IDLE, 8'($urandom), 7'($urandom), 1'b1);
      end else begin
        // Broken sentence: left open, the next dollar restarts it
        queue_char(nsa_pkg::CH_DOLLAR);
        repeat ($urandom_range(0, 8)) queue_char(body_char());
      end
      queue_pops_and_reads();
    end

    @(posedge rst_ni);
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0);
    // Let any stray word show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("nmea_sentence_assembler_top verification clean");
    end else begin
      $display("nmea_sentence_assembler_top verification failed");
    end
    $finish;
  end

endmodule
